// ===== design/dfm_pkg.sv =====
`default_nettype none

package dfm_pkg;

    localparam int unsigned HDR_BYTES       = 8;
    localparam int unsigned DFM_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_SHORT = 2'd2
    } kind_t;

    // Header byte positions
    localparam logic [2:0] HDR_POS_TYPE_HI = 3'd4;
    localparam logic [2:0] HDR_POS_VERSION = 3'd6;
    localparam logic [2:0] HDR_POS_LAST    = 3'd7;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  body_byte;
        logic [15:0] frame_type;
        logic [7:0]  version;
        logic [7:0]  reserved_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t entry;
    } push_t;

endpackage

`default_nettype wire

// ===== design/dfm_if.sv =====
`default_nettype none

interface dfm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface dfm_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [15:0] frame_type;
    logic [7:0]  version;
    logic [7:0]  reserved_byte;
    logic        last;

    modport source (
        output valid, output kind, output body_byte, output frame_type,
        output version, output reserved_byte, output last, input ready
    );
    modport sink (
        input valid, input kind, input body_byte, input frame_type,
        input version, input reserved_byte, input last, output ready
    );
endinterface

`default_nettype wire

// ===== design/dfm_front.sv =====
`default_nettype none

module dfm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    stream_byte,
    output dfm_pkg::push_t     push
);
    import dfm_pkg::*;

    logic        in_body_reg, in_body_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] length_reg, length_next;
    logic [15:0] type_reg, type_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  reserved_reg, reserved_next;
    logic [31:0] remaining_reg, remaining_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg      <= 1'b0;
            header_count_reg <= '0;
            length_reg       <= '0;
            type_reg         <= '0;
            version_reg      <= '0;
            reserved_reg     <= '0;
            remaining_reg    <= '0;
        end
        else
        begin
            in_body_reg      <= in_body_next;
            header_count_reg <= header_count_next;
            length_reg       <= length_next;
            type_reg         <= type_next;
            version_reg      <= version_next;
            reserved_reg     <= reserved_next;
            remaining_reg    <= remaining_next;
        end
    end

    always_comb
    begin
        in_body_next      = in_body_reg;
        header_count_next = header_count_reg;
        length_next       = length_reg;
        type_next         = type_reg;
        version_next      = version_reg;
        reserved_next     = reserved_reg;
        remaining_next    = remaining_reg;

        push.push               = 1'b0;
        push.entry.kind         = KIND_BODY;
        push.entry.body_byte    = '0;
        push.entry.frame_type   = type_reg;
        push.entry.version      = version_reg;
        push.entry.reserved_byte = reserved_reg;
        push.entry.last         = 1'b0;

        if (accept)
        begin
            if (in_body_reg)
            begin
                push.push            = 1'b1;
                push.entry.body_byte = stream_byte;
                push.entry.last      = (remaining_reg <= 32'd1);
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - 32'd1;
                end
                if (remaining_next == '0)
                begin
                    in_body_next      = 1'b0;
                    header_count_next = '0;
                end
            end
            else
            begin
                case (header_count_reg) inside
                    [3'd0:3'd3]:
                        length_next = {length_reg[23:0], stream_byte};
                    [HDR_POS_TYPE_HI:3'd5]:
                        type_next = {type_reg[7:0], stream_byte};
                    HDR_POS_VERSION:
                        version_next = stream_byte;
                    default:
                        reserved_next = stream_byte;
                endcase

                if (header_count_reg != HDR_POS_LAST)
                begin
                    header_count_next = header_count_reg + 3'd1;
                end
                else
                begin
                    // Header complete: classify the total length
                    header_count_next        = '0;
                    push.entry.reserved_byte = stream_byte;
                    if (length_reg < 32'(HDR_BYTES))
                    begin
                        push.push       = 1'b1;
                        push.entry.kind = KIND_SHORT;
                        push.entry.last = 1'b1;
                    end
                    else if (length_reg == 32'(HDR_BYTES))
                    begin
                        push.push       = 1'b1;
                        push.entry.kind = KIND_EMPTY;
                        push.entry.last = 1'b1;
                    end
                    else
                    begin
                        remaining_next = length_reg - 32'(HDR_BYTES);
                        in_body_next   = 1'b1;
                    end
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_body_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> remaining_reg != '0)
        else $error("in body with no bytes left");

    a_last_leaves_body: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_body_reg && remaining_reg == 32'd1 |=>
            !in_body_reg && header_count_reg == '0)
        else $error("final body byte did not return to header parsing");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> accept)
        else $error("result pushed without an accepted transaction");
`endif

endmodule

`default_nettype wire

// ===== design/dfm_queue.sv =====
`default_nettype none

module dfm_queue #(
    parameter int unsigned DEPTH = dfm_pkg::DFM_QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dfm_pkg::push_t   push,
    output logic                  full,
    output logic                  head_valid,
    output dfm_pkg::result_t      head,
    input  wire logic             pop_ready
);
    import dfm_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = head_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !full)
        else $error("transaction pushed into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ===== design/length_prefixed_message_deframer.sv =====
// A result is written into the result queue when the byte that causes it is accepted; tx is driven from the queue head.
// Throughput: one byte per cycle; rx.ready drops only when the result queue is full.
// The queue between the header/body parser and the output holds DEPTH results.
// Reset (rst_n, asynchronous, active low) clears the parser to header parsing and
// empties the queue; header fields and the body count reset to zero.
`default_nettype none

module length_prefixed_message_deframer #(
    parameter int unsigned DEPTH = dfm_pkg::DFM_QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dfm_byte_if.sink      rx,
    dfm_result_if.source  tx
);
    import dfm_pkg::*;

    push_t   push;
    result_t head;
    logic    full;
    logic    head_valid;

    assign rx.ready = !full;

    dfm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (rx.valid && rx.ready),
        .stream_byte (rx.stream_byte),
        .push        (push)
    );

    dfm_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop_ready  (tx.ready)
    );

    assign tx.valid         = head_valid;
    assign tx.kind          = head.kind;
    assign tx.body_byte     = head.body_byte;
    assign tx.frame_type    = head.frame_type;
    assign tx.version       = head.version;
    assign tx.reserved_byte = head.reserved_byte;
    assign tx.last          = head.last;

endmodule

`default_nettype wire

// ===== test/deframe_checker.sv =====
`default_nettype none

module deframe_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    dfm_byte_if       rx,
    dfm_result_if     tx,
    output int        mismatches,
    output int        pending
);

    // Shadow parser state
    logic        in_body;
    logic [2:0]  hdr_pos;
    logic [31:0] total_len;
    logic [15:0] msg_type;
    logic [7:0]  ver_field;
    logic [7:0]  rsv_field;
    logic [31:0] body_left;

    dfm_pkg::result_t expected_q[$];

    task automatic tag_result(inout dfm_pkg::result_t r);
        r.frame_type    = msg_type;
        r.version       = ver_field;
        r.reserved_byte = rsv_field;
    endtask

    // Advance the shadow parser by one byte; report the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, output bit produced,
                              output dfm_pkg::result_t r);
        produced = 1'b0;
        r = '0;
        if (in_body) begin
            r.kind      = dfm_pkg::KIND_BODY;
            r.body_byte = b;
            r.last      = (body_left <= 32'd1);
            tag_result(r);
            produced = 1'b1;
            if (body_left != 32'd0)
                body_left = body_left - 32'd1;
            if (body_left == 32'd0)
            begin
                in_body = 1'b0;
                hdr_pos = 3'd0;
            end
        end
        else
        begin
            if (hdr_pos < dfm_pkg::HDR_POS_TYPE_HI)
                total_len = {total_len[23:0], b};
            else if (hdr_pos < dfm_pkg::HDR_POS_VERSION)
                msg_type = {msg_type[7:0], b};
            else if (hdr_pos == dfm_pkg::HDR_POS_VERSION)
                ver_field = b;
            else
                rsv_field = b;

            if (hdr_pos != dfm_pkg::HDR_POS_LAST)
                hdr_pos = hdr_pos + 3'd1;
            else
            begin
                hdr_pos = 3'd0;
                tag_result(r);
                if (total_len < dfm_pkg::HDR_BYTES)
                begin
                    r.kind   = dfm_pkg::KIND_SHORT;
                    r.last   = 1'b1;
                    produced = 1'b1;
                end
                else if (total_len == dfm_pkg::HDR_BYTES)
                begin
                    r.kind   = dfm_pkg::KIND_EMPTY;
                    r.last   = 1'b1;
                    produced = 1'b1;
                end
                else
                begin
                    body_left = total_len - dfm_pkg::HDR_BYTES;
                    in_body   = 1'b1;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit               produced;
        dfm_pkg::result_t want;
        dfm_pkg::result_t got;

        if (!rst_n)
        begin
            in_body   = 1'b0;
            hdr_pos   = 3'd0;
            total_len = '0;
            msg_type  = '0;
            ver_field = '0;
            rsv_field = '0;
            body_left = '0;
            expected_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // Check the output first: a result never comes from the byte taken this edge.
            if (tx.valid && tx.ready)
            begin
                got.kind          = dfm_pkg::kind_t'(tx.kind);
                got.body_byte     = tx.body_byte;
                got.frame_type    = tx.frame_type;
                got.version       = tx.version;
                got.reserved_byte = tx.reserved_byte;
                got.last          = tx.last;
                if (expected_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d byte %02h type %04h",
                                 tx.kind, got.body_byte, got.frame_type,
                                 " ver %02h rsv %02h last %0b",
                                 got.version, got.reserved_byte, got.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.body_byte !== want.body_byte ||
                        got.frame_type !== want.frame_type ||
                        got.version !== want.version ||
                        got.reserved_byte !== want.reserved_byte || got.last !== want.last)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp kind %0d byte %02h type %04h",
                                     want.kind, want.body_byte, want.frame_type,
                                     " ver %02h rsv %02h last %0b",
                                     want.version, want.reserved_byte, want.last,
                                     " / got kind %0d byte %02h type %04h",
                                     tx.kind, got.body_byte, got.frame_type,
                                     " ver %02h rsv %02h last %0b",
                                     got.version, got.reserved_byte, got.last);
                    end
                end
            end

            if (rx.valid && rx.ready)
            begin
                parse_byte(rx.stream_byte, produced, want);
                if (produced)
                    expected_q.push_back(want);
            end
            pending = expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;

    localparam int STALL_LIMIT  = 4000;
    localparam int BYTE_TARGET  = 1550;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   bytes_sent;
    bit   calm;

    dfm_byte_if   rx_ch ();
    dfm_result_if tx_ch ();

    length_prefixed_message_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    deframe_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .tx         (tx_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 33);
    endfunction

    // Offer one byte, hold it until the transaction completes.
    task automatic send_byte(input logic [7:0] b);
        while (take_break())
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.stream_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
        calm = (bytes_sent >= CALM_FIRST) && (bytes_sent < CALM_LAST);
        @(negedge clk);
    endtask

    task automatic send_header(input logic [31:0] len, input logic [15:0] msg_type,
                               input logic [7:0] ver, input logic [7:0] rsv);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(msg_type[15:8]);
        send_byte(msg_type[7:0]);
        send_byte(ver);
        send_byte(rsv);
    endtask

    task automatic send_body(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom()));
    endtask

    // Result side: stall at random, except in the calm stretch.
    initial
    begin
        tx_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            tx_ch.ready <= !take_break();
        end
    end

    // Give up after too many cycles without any transaction.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("length_prefixed_message_deframer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int          pick;
        logic [31:0] len;

        rst_n             <= 1'b0;
        rx_ch.valid       <= 1'b0;
        rx_ch.stream_byte <= '0;
        bytes_sent = 0;
        calm       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short length with all-ones tags, empty body, two-byte body.
        send_header(32'd0, 16'hFFFF, 8'hFF, 8'hFF);
        send_header(32'd8, 16'h0000, 8'h00, 8'h00);
        send_header(32'd10, 16'h5AA5, 8'h01, 8'h80);
        send_byte(8'hFF);
        send_byte(8'h00);

        while (bytes_sent < BYTE_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                len = $urandom_range(0, 7);
            else if (pick < 24)
                len = 32'd8;
            else if (pick < 94)
                len = 32'd9 + $urandom_range(0, 31);
            else
                len = 32'd41 + $urandom_range(0, 270);
            send_header(len, 16'($urandom()), 8'($urandom()), 8'($urandom()));
            if (len > 32'd8)
                send_body(len - 32'd8);
        end

        // Largest length: the body count must not wrap; stream part of it.
        send_header(32'hFFFF_FFFF, 16'($urandom()), 8'($urandom()), 8'($urandom()));
        send_body(24);
        rx_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("length_prefixed_message_deframer regression: pass");
        else
            $display("length_prefixed_message_deframer regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/dfm_pkg.sv
design/dfm_if.sv
design/dfm_front.sv
design/dfm_queue.sv
design/length_prefixed_message_deframer.sv
test/deframe_checker.sv
test/tb_top.sv
